// ----- hw/rtl/lzbc_pkg.sv -----
// Shared types and constants for the LZ block copy decoder.
`timescale 1ns / 1ps
`default_nettype none
package lzbc_pkg;

	localparam int unsigned DIST_W  = 17;
	localparam int unsigned COUNT_W = 17;
	localparam int unsigned LEN_W   = 6;
	localparam int unsigned QDEPTH  = 4;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [7:0] COPY_LEN_MASK = 8'h3f;

	typedef struct packed {
		logic       start_req;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
		logic       bad_distance;
	} out_item_t;

	// One unit of work for the back end: a literal byte or a whole copy.
	typedef struct packed {
		logic              is_copy;
		logic              restart;
		logic [7:0]        lit_byte;
		logic [DIST_W-1:0] copy_dist;
		logic [LEN_W-1:0]  len_m1;
	} job_t;

	function automatic logic [COUNT_W-1:0] count_inc(input logic [COUNT_W-1:0] c);
		count_inc = (c == COUNT_MAX) ? c : c + COUNT_W'(1);
	endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/lzbc_front.sv -----
// Stream parser: classifies command, distance and literal bytes into jobs.
`timescale 1ns / 1ps
`default_nettype none
module lzbc_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  lzbc_pkg::in_item_t  item,
	output logic                full,
	input  wire                 q_full,
	output logic                job_push,
	output lzbc_pkg::job_t      job
);
	import lzbc_pkg::*;

	typedef enum logic [3:0] {
		PH_CMD = 4'b0001,
		PH_LIT = 4'b0010,
		PH_DHI = 4'b0100,
		PH_DLO = 4'b1000
	} phase_t;

	phase_t           phase_q, eff_phase;
	logic [6:0]       lit_left_q;
	logic [LEN_W-1:0] copy_len_q;
	logic [7:0]       dist_hi_q;
	logic             restart_pend_q;
	logic             accept;
	logic [7:0]       b;

	assign full      = q_full;
	assign accept    = push && !q_full;
	assign b         = item.data_byte;
	assign eff_phase = item.start_req ? PH_CMD : phase_q;

	always_comb begin
		job_push      = accept && (eff_phase == PH_LIT || eff_phase == PH_DLO);
		job.is_copy   = (eff_phase == PH_DLO);
		job.restart   = restart_pend_q;
		job.lit_byte  = b;
		job.copy_dist = DIST_W'({dist_hi_q, b}) + DIST_W'(1);
		job.len_m1    = copy_len_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_CMD;
			lit_left_q     <= '0;
			copy_len_q     <= '0;
			dist_hi_q      <= '0;
			restart_pend_q <= 1'b0;
		end else if (accept) begin
			if (item.start_req) begin
				restart_pend_q <= 1'b1;
			end else if (job_push) begin
				restart_pend_q <= 1'b0;
			end
			unique case (eff_phase)
				PH_CMD: begin
					if (!b[7]) begin
						lit_left_q <= b[6:0];
						phase_q    <= PH_LIT;
					end else begin
						copy_len_q <= LEN_W'(b & COPY_LEN_MASK);
						dist_hi_q  <= '0;
						phase_q    <= b[6] ? PH_DLO : PH_DHI;
					end
				end
				PH_LIT: begin
					if (lit_left_q == '0) begin
						phase_q <= PH_CMD;
					end else begin
						lit_left_q <= lit_left_q - 7'd1;
					end
				end
				PH_DHI: begin
					dist_hi_q <= b;
					phase_q   <= PH_DLO;
				end
				PH_DLO: begin
					phase_q <= PH_CMD;
				end
				default: begin
					phase_q <= PH_CMD;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/lzbc_queue.sv -----
// Small job queue between parser and executor.
`timescale 1ns / 1ps
`default_nettype none
module lzbc_queue (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             wr_en,
	input  lzbc_pkg::job_t  wr_job,
	output logic            full,
	input  wire             rd_en,
	output logic            empty,
	output lzbc_pkg::job_t  rd_job
);
	import lzbc_pkg::*;

	localparam int unsigned IW = $clog2(QDEPTH);

	job_t          slot_q [QDEPTH];
	logic [IW-1:0] wr_ptr_q, rd_ptr_q;
	logic [IW:0]   cnt_q;
	logic          do_wr, do_rd;

	assign full   = (cnt_q == (IW+1)'(QDEPTH));
	assign empty  = (cnt_q == '0);
	assign do_wr  = wr_en && !full;
	assign do_rd  = rd_en && !empty;
	assign rd_job = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + IW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + IW'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + (IW+1)'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - (IW+1)'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/lzbc_back.sv -----
// Executor: writes literals, replays copies from the history memory, output register.
`timescale 1ns / 1ps
`default_nettype none
module lzbc_back #(
	parameter int unsigned HISTORY_DEPTH = 65536
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 job_valid,
	input  lzbc_pkg::job_t      job,
	output logic                job_pop,
	output logic                empty,
	input  wire                 pop,
	output lzbc_pkg::out_item_t result
);
	import lzbc_pkg::*;

	localparam int unsigned AW = $clog2(HISTORY_DEPTH);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_READ = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t             state_q;
	logic [7:0]         mem [HISTORY_DEPTH];
	logic [7:0]         rd_data_q;
	logic [AW-1:0]      rd_addr;
	logic               rd_en;
	logic [AW-1:0]      wp_q;
	logic [COUNT_W-1:0] cnt_q, cnt_base;
	logic [DIST_W-1:0]  dist_q;
	logic [LEN_W-1:0]   rem_q;
	logic               bad_q, bad_now;
	logic               out_valid_q;
	out_item_t          out_q, out_next;
	logic               out_free, out_load;
	logic               mem_we;
	logic [7:0]         wdata;
	logic [DIST_W:0]    diff, diff_adj;

	assign out_free = !out_valid_q || pop;
	assign empty    = !out_valid_q;
	assign result   = out_q;
	assign cnt_base = job.restart ? '0 : cnt_q;

	// Source slot: write pointer minus distance, folded back into the ring.
	always_comb begin
		diff     = (DIST_W+1)'(wp_q) - {1'b0, dist_q};
		diff_adj = diff[DIST_W] ? diff + (DIST_W+1)'(HISTORY_DEPTH) : diff;
		rd_addr  = diff_adj[AW-1:0];
		bad_now  = (dist_q > cnt_q) || (dist_q > DIST_W'(HISTORY_DEPTH));
		rd_en    = (state_q == ST_READ);
	end

	always_comb begin
		job_pop  = 1'b0;
		out_load = 1'b0;
		out_next = out_q;
		wdata    = job.lit_byte;
		unique case (state_q)
			ST_IDLE: begin
				if (job_valid) begin
					if (job.is_copy) begin
						job_pop = 1'b1;
					end else if (out_free) begin
						job_pop  = 1'b1;
						out_load = 1'b1;
						out_next = '{out_byte: job.lit_byte, last_of_run: 1'b1,
							bad_distance: 1'b0};
					end
				end
			end
			ST_EMIT: begin
				wdata = bad_q ? 8'h00 : rd_data_q;
				if (out_free) begin
					out_load = 1'b1;
					out_next = '{out_byte: wdata, last_of_run: (rem_q == '0),
						bad_distance: bad_q};
				end
			end
			default: begin
			end
		endcase
		mem_we = out_load;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wp_q] <= wdata;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= out_next;
		end
		if (state_q == ST_READ) begin
			bad_q <= bad_now;
		end
		if (state_q == ST_IDLE && job_pop) begin
			dist_q <= job.copy_dist;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			wp_q        <= '0;
			cnt_q       <= '0;
			rem_q       <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			if (mem_we) begin
				wp_q <= (wp_q == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_q + AW'(1);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (job_pop) begin
						if (job.is_copy) begin
							cnt_q   <= cnt_base;
							rem_q   <= job.len_m1;
							state_q <= ST_READ;
						end else begin
							cnt_q <= count_inc(cnt_base);
						end
					end
				end
				ST_READ: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_load) begin
						cnt_q <= count_inc(cnt_q);
						if (rem_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							rem_q   <= rem_q - LEN_W'(1);
							state_q <= ST_READ;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> state_q == ST_IDLE)
		else $error("job taken outside idle");

	a_copy_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && out_load && rem_q == '0) |=> state_q == ST_IDLE)
		else $error("copy did not end after its last beat");

	a_read_then_emit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |=> state_q == ST_EMIT && $stable(wp_q))
		else $error("history read not followed by emit");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && out_load) |=> result.bad_distance == $past(bad_q))
		else $error("error flag lost on copy beat");

endmodule
`default_nettype wire

// ----- hw/rtl/lz_block_copy_decoder.sv -----
// Top level of the LZ block copy decoder: parser, job queue and executor.
//
// Usage: compressed bytes enter on the input queue port (push/full, item);
// decompressed bytes leave on the result queue port (empty/pop, result).
// An input beat is taken when push is high and full is low; a result beat
// leaves when pop is high and empty is low.
// Command and distance bytes produce no result. A literal byte reaches the
// result port through the job queue and the output register; literals flow
// at one per cycle, between copies, while the receiver keeps popping. A copy
// picks up its job and then reads the history memory and emits a byte in turn
// for each byte, paced by the single memory port and its registered read;
// the parser keeps taking beats until the four-entry job queue fills, then
// raises full. A copy byte whose source lies before the stream start, or
// beyond the history, is zero with bad_distance set, and is still recorded.
// Reset clears parse state, queue, output register, write pointer and byte
// count; history contents are not cleared, and need not be, since every read
// is checked against the byte count. start_req restarts parsing and the count.
// When the receiver stalls, the result holds in the output register and the
// executor, then the queue, then the input side back up in turn.
`timescale 1ns / 1ps
`default_nettype none
module lz_block_copy_decoder #(
	parameter int unsigned HISTORY_DEPTH = 65536
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	output logic                full,
	input  lzbc_pkg::in_item_t  item,
	output logic                empty,
	input  wire                 pop,
	output lzbc_pkg::out_item_t result
);
	import lzbc_pkg::*;

	logic q_full, q_empty, job_push, job_pop;
	job_t job_in, job_out;

	// Parse bytes into literal and copy jobs.
	lzbc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item     (item),
		.full     (full),
		.q_full   (q_full),
		.job_push (job_push),
		.job      (job_in)
	);

	// Decouple parsing from the long-running copies.
	lzbc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (job_push),
		.wr_job (job_in),
		.full   (q_full),
		.rd_en  (job_pop),
		.empty  (q_empty),
		.rd_job (job_out)
	);

	// Execute jobs against the history and drive the result register.
	lzbc_back #(
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (!q_empty),
		.job       (job_out),
		.job_pop   (job_pop),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule
`default_nettype wire

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the LZ block copy decoder (lz_block_copy_decoder).
`timescale 1ns / 1ps
module tb;
	import lzbc_pkg::*;

	localparam int HIST_DEPTH     = 65536;
	localparam int RESET_CYCLES   = 4;
	// Longest legal quiet stretch is the receiver hold-off plus one full copy
	// under random stalls; allow several times that.
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_CYCLES    = 400;
	localparam int END_SETTLE     = 300;
	localparam int PHASE_BEATS    = 18;
	localparam int MAX_REPORTS    = 30;

	// Command byte layout: bit 7 picks copy over literal, bit 6 picks the short
	// (one distance byte) copy form.
	localparam logic       CMD_LITERAL    = 1'b0;
	localparam logic [1:0] CMD_COPY_SHORT = 2'b11;
	localparam logic [1:0] CMD_COPY_LONG  = 2'b10;

	typedef enum logic [1:0] {
		PH_CMD,
		PH_LIT,
		PH_DHI,
		PH_DLO
	} parse_ph_t;

	logic      clk;
	logic      arst_n = 1'b0;
	logic      push   = 1'b0;
	logic      pop    = 1'b0;
	in_item_t  item   = '0;
	logic      full;
	logic      empty;
	out_item_t result;

	lz_block_copy_decoder #(
		.HISTORY_DEPTH(HIST_DEPTH)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (full),
		.item  (item),
		.empty (empty),
		.pop   (pop),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Decoder state as the testbench sees it. Updated once per accepted
	// input beat; every byte the stream should produce lands in
	// expected_bytes in output order.
	// ------------------------------------------------------------------
	parse_ph_t   model_phase = PH_CMD;
	logic [6:0]  lit_left    = '0;
	logic [5:0]  copy_m1     = '0;
	logic [7:0]  dist_hi     = '0;
	logic [7:0]  hist [0:HIST_DEPTH-1];
	logic [15:0] wr_ptr      = '0;
	logic [16:0] byte_count  = '0;
	out_item_t   expected_bytes [$];

	int errors     = 0;
	int beats_sent = 0;

	// Sender idle rate lives with the main thread; the stall rate and the
	// hold-off request are handed to the receiver process by NBA.
	int send_idle_pct = 0;
	int stall_pct     = 0;
	int hold_token    = 0;
	int hold_seen     = 0;
	int hold_left     = 0;

	// Log one produced byte: queue it, write it to history, bump the count.
	task automatic record_byte(input logic [7:0] v, input logic last, input logic bad);
		out_item_t e;
		e.out_byte     = v;
		e.last_of_run  = last;
		e.bad_distance = bad;
		expected_bytes.insert(expected_bytes.size(), e);
		hist[wr_ptr] = v;
		wr_ptr = wr_ptr + 16'd1;
		if (byte_count != COUNT_MAX)
			byte_count = byte_count + 17'd1;
	endtask

	// Advance the parser by one accepted beat and predict its output bytes.
	task automatic model_accept(input in_item_t beat);
		logic [7:0]  b;
		logic [16:0] copy_dist;
		logic        bad;
		logic [7:0]  v;
		b = beat.data_byte;
		// A start beat drops whatever was in flight; history survives.
		if (beat.start_req) begin
			model_phase = PH_CMD;
			lit_left    = '0;
			copy_m1     = '0;
			dist_hi     = '0;
			byte_count  = '0;
		end
		case (model_phase)
			PH_CMD: begin
				if (b[7] == CMD_LITERAL) begin
					lit_left    = b[6:0];
					model_phase = PH_LIT;
				end else begin
					copy_m1     = b[5:0] & COPY_LEN_MASK[5:0];
					dist_hi     = '0;
					model_phase = (b[7:6] == CMD_COPY_SHORT) ? PH_DLO : PH_DHI;
				end
			end
			PH_LIT: begin
				record_byte(b, 1'b1, 1'b0);
				if (lit_left == 0)
					model_phase = PH_CMD;
				else
					lit_left = lit_left - 7'd1;
			end
			PH_DHI: begin
				dist_hi     = b;
				model_phase = PH_DLO;
			end
			default: begin
				copy_dist = {1'b0, dist_hi, b} + 17'd1;
				// Check the source per byte: an overlapping copy that starts
				// before the stream can become valid partway through.
				for (int i = 0; i <= copy_m1; i++) begin
					bad = (copy_dist > byte_count) || (copy_dist > HIST_DEPTH);
					v   = bad ? 8'h00 : hist[wr_ptr - copy_dist[15:0]];
					record_byte(v, i == copy_m1, bad);
				end
				copy_m1     = '0;
				dist_hi     = '0;
				model_phase = PH_CMD;
			end
		endcase
	endtask

	// ------------------------------------------------------------------
	// Input side. Hold push high until the beat is taken; leave it high on
	// return so back-to-back beats need no extra edge. Anything that lets
	// time pass without a new beat must drop push itself.
	// ------------------------------------------------------------------
	task automatic send_beat(input logic st, input logic [7:0] b);
		in_item_t beat;
		beat.start_req = st;
		beat.data_byte = b;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= beat;
		@(posedge clk);
		while (full !== 1'b0)
			@(posedge clk);
		model_accept(beat);
		beats_sent++;
	endtask

	task automatic send_literal_cmd(input logic st, input logic [6:0] n_m1);
		send_beat(st, {CMD_LITERAL, n_m1});
	endtask

	// Encode a copy of len_m1+1 bytes at the given distance (1..65536).
	task automatic send_copy(input logic st, input logic [5:0] len_m1,
	                         input int unsigned copy_dist, input bit short_form);
		logic [15:0] code;
		code = 16'(copy_dist - 1);
		if (short_form) begin
			send_beat(st, {CMD_COPY_SHORT, len_m1});
			send_beat(1'b0, code[7:0]);
		end else begin
			send_beat(st, {CMD_COPY_LONG, len_m1});
			send_beat(1'b0, code[15:8]);
			send_beat(1'b0, code[7:0]);
		end
	endtask

	// Drop push and wait until every predicted byte has come out.
	task automatic wait_drain();
		push <= 1'b0;
		@(posedge clk);
		while (expected_bytes.size() != 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Output side: random stalls, plus a long hold-off on request.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_seen != hold_token) begin
			hold_seen <= hold_token;
			hold_left <= HOLD_CYCLES;
			pop       <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			pop       <= 1'b0;
		end else begin
			pop <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	task automatic flag_mismatch(input string field, input logic [7:0] want_v,
	                             input logic [7:0] got_v);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("%0t: %s mismatch: expected %h, actual %h", $time, field, want_v, got_v);
	endtask

	// Compare every accepted result beat against the oldest prediction.
	out_item_t want;
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (expected_bytes.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: unexpected result: expected none, actual %h/%b/%b",
					         $time, result.out_byte, result.last_of_run,
					         result.bad_distance);
			end else begin
				want = expected_bytes.pop_front();
				if (result.out_byte !== want.out_byte)
					flag_mismatch("out_byte", want.out_byte, result.out_byte);
				if (result.last_of_run !== want.last_of_run)
					flag_mismatch("last_of_run", want.last_of_run, result.last_of_run);
				if (result.bad_distance !== want.bad_distance)
					flag_mismatch("bad_distance", want.bad_distance, result.bad_distance);
			end
		end
	end

	// Bail out if no beat moves on either side for too long.
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((push && full === 1'b0) || (pop && empty === 1'b0))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog: no beat for %0d cycles, %0d bytes outstanding",
			         $time, quiet_cycles, expected_bytes.size());
			$display("Some tests failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Shortest literal run with a zero byte, then a short run with the
	// all-ones and alternating byte patterns.
	task automatic test_literal_runs();
		send_literal_cmd(1'b1, 7'd0);
		send_beat(1'b0, 8'h00);
		send_literal_cmd(1'b0, 7'd2);
		send_beat(1'b0, 8'hff);
		send_beat(1'b0, 8'h55);
		send_beat(1'b0, 8'haa);
	endtask

	// Both copy forms: one byte at distance 1, a 64-byte overlapping copy
	// that repeats a two-byte pattern, and a long-form 64-byte copy.
	task automatic test_copy_forms();
		send_copy(1'b0, 6'd0, 1, 1'b1);
		send_copy(1'b0, 6'd63, 2, 1'b1);
		send_copy(1'b0, 6'd63, 69, 1'b0);
	endtask

	// Copies that reach before the stream start: one that recovers partway
	// once enough bytes exist, and one at the largest encodable distance.
	task automatic test_bad_distance();
		send_literal_cmd(1'b1, 7'd1);
		send_beat(1'b0, 8'h11);
		send_beat(1'b0, 8'h22);
		send_copy(1'b0, 6'd4, 3, 1'b1);
		send_copy(1'b0, 6'd0, HIST_DEPTH, 1'b0);
	endtask

	// Restart in the middle of a literal run and in the middle of a long
	// distance; the count clears, so a distance-1 copy right after is bad.
	task automatic test_restart();
		send_literal_cmd(1'b0, 7'd5);
		send_beat(1'b0, 8'h77);
		send_copy(1'b1, 6'd0, 1, 1'b1);
		send_beat(1'b0, {CMD_COPY_LONG, 6'd1});
		send_beat(1'b0, 8'h00);
		send_literal_cmd(1'b1, 7'd0);
		send_beat(1'b0, 8'h9a);
	endtask

	// Hold off the receiver while long copies keep coming, so the job queue
	// fills and full rises; then pause the sender until everything drains.
	task automatic test_backpressure();
		hold_token <= hold_token + 1;
		send_literal_cmd(1'b1, 7'd15);
		repeat (16)
			send_beat(1'b0, 8'($urandom_range(0, 255)));
		repeat (8)
			send_copy(1'b0, 6'd63, $urandom_range(1, 16), 1'b1);
		wait_drain();
	endtask

	// One well-formed command with random content, or a burst of noise.
	// A command following a broken sequence carries start_req to resync.
	task automatic send_random_sequence();
		int unsigned kind;
		int unsigned n;
		int unsigned reach;
		int unsigned pick;
		int unsigned copy_dist;
		logic        st;
		logic [5:0]  len_m1;
		kind = $urandom_range(0, 99);
		st   = (model_phase != PH_CMD) || ($urandom_range(0, 99) < 8);
		if (kind < 45) begin
			n = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 7);
			send_literal_cmd(st, 7'(n));
			repeat (n + 1)
				send_beat(1'b0, 8'($urandom_range(0, 255)));
		end else if (kind < 90) begin
			len_m1 = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
			                                     : 6'($urandom_range(0, 7));
			reach  = st ? 0 : ((byte_count > HIST_DEPTH) ? HIST_DEPTH : byte_count);
			pick   = $urandom_range(0, 9);
			if (reach == 0 || pick == 0) begin
				// Reach past what exists.
				copy_dist = reach + $urandom_range(1, 16);
				if (copy_dist > HIST_DEPTH)
					copy_dist = HIST_DEPTH;
			end else if (pick < 5) begin
				// Short distances make the copy overlap itself.
				copy_dist = $urandom_range(1, (reach < 4) ? reach : 4);
			end else begin
				copy_dist = $urandom_range(1, reach);
			end
			send_copy(st, len_m1, copy_dist, copy_dist <= 256 && $urandom_range(0, 1) == 1);
		end else begin
			repeat ($urandom_range(1, 3))
				send_beat($urandom_range(0, 99) < 20, 8'($urandom_range(0, 255)));
		end
	endtask

	task automatic run_random_phase(input int send_pct, input int recv_pct);
		int phase_end;
		send_idle_pct = send_pct;
		stall_pct    <= recv_pct;
		phase_end     = beats_sent + PHASE_BEATS;
		while (beats_sent < phase_end)
			send_random_sequence();
	endtask

	task automatic test_random_traffic();
		run_random_phase(0, 0);
		run_random_phase(45, 0);
		run_random_phase(0, 45);
		run_random_phase(25, 25);
		send_idle_pct = 0;
		stall_pct    <= 0;
		wait_drain();
	endtask

	// A longer stream: short literal runs interleaved with long-form 64-byte
	// copies from anywhere in what has been produced so far.
	task automatic test_long_stream();
		int unsigned reach;
		for (int k = 0; k < 2; k++) begin
			send_literal_cmd(k == 0, 7'd7);
			repeat (8)
				send_beat(1'b0, 8'($urandom_range(0, 255)));
			reach = (byte_count > HIST_DEPTH) ? HIST_DEPTH : byte_count;
			send_copy(1'b0, 6'd63, $urandom_range(1, reach), 1'b0);
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_literal_runs();
		test_copy_forms();
		test_bad_distance();
		test_restart();
		test_backpressure();
		test_random_traffic();
		test_long_stream();

		// Drain, then give a stray late byte time to show up.
		wait_drain();
		repeat (END_SETTLE) @(posedge clk);

		if (expected_bytes.size() != 0)
			$display("%0t: %0d expected bytes never arrived", $time, expected_bytes.size());
		if (errors == 0 && expected_bytes.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/lzbc_pkg.sv
hw/rtl/lzbc_front.sv
hw/rtl/lzbc_queue.sv
hw/rtl/lzbc_back.sv
hw/rtl/lz_block_copy_decoder.sv
tb/sv/tb.sv
